/* sv/ftdt_pkg.sv */
// ----------------------------------------------------------------------------
// Float to decimal text package
// Shared types, codes, constants and the BCD correction used by the
// float to decimal text converter.
// ----------------------------------------------------------------------------
package ftdt_pkg;

  // Fraction digits printed at most (default for the top level parameter).
  localparam int unsigned FRAC_DIGITS_DEF = 7;
  localparam int unsigned FRAC_DIGITS_MAX = 7;
  localparam int unsigned KEPT_W          = $clog2(FRAC_DIGITS_MAX + 1);

  // Integer part: up to 31 bits, converted two bits per cycle into 10 digits.
  localparam int unsigned INT_DIGITS   = 10;
  localparam int unsigned NDIG_W       = 4;
  localparam int unsigned BIN_W        = 32;
  localparam int unsigned DABBLE_STEPS = BIN_W / 2;
  localparam int unsigned STEP_W       = $clog2(DABBLE_STEPS);
  localparam int unsigned BCD_W        = 4 * INT_DIGITS;

  // Fraction part in 24-bit fixed point.
  localparam int unsigned FRAC_W = 24;
  // Fixed point word: 31 integer bits and 24 fraction bits.
  localparam int unsigned FIX_W  = 55;
  localparam int unsigned IPART_W = 31;

  localparam int unsigned ROOM_W        = 6;
  localparam logic [5:0]  ROOM_MAX      = 6'd32;
  localparam logic [5:0]  ROOM_ZERO_MIN = 6'd4;

  // Biased exponent limits: 127 + 31 is too large, below 127 - 23 too small.
  localparam logic [7:0] EXP_LARGE      = 8'd158;
  localparam logic [7:0] EXP_SMALL      = 8'd104;
  // Right shift of {mant, 31 zeros} is 157 minus the biased exponent.
  localparam logic [7:0] EXP_SHIFT_BASE = 8'd157;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_LARGE = 2'd1,
    ST_SMALL = 2'd2,
    ST_ROOM  = 2'd3
  } ftdt_status_e;

  typedef struct packed {
    logic [31:0] float_bits;
    logic [5:0]  capacity;
  } ftdt_in_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic [1:0] status;
    logic       last;
  } ftdt_out_t;

  // Everything the character emitter needs besides the digits themselves.
  typedef struct packed {
    logic              fail;
    ftdt_status_e      status;
    logic              neg;
    logic [NDIG_W-1:0] nd;
    logic [KEPT_W-1:0] kept;
  } ftdt_job_t;

  typedef enum logic [1:0] {
    CT_IDLE,
    CT_CONV,
    CT_CHECK,
    CT_HAND
  } ftdt_ctrl_e;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SIGN,
    PH_INT,
    PH_DOT,
    PH_FRAC,
    PH_TERM,
    PH_FAIL
  } ftdt_phase_e;

  // Double dabble correction: every BCD digit of 5 or more gets 3 added.
  function automatic logic [BCD_W-1:0] dabble_adj(input logic [BCD_W-1:0] b);
    logic [BCD_W-1:0] r;
    r = b;
    for (int i = 0; i < INT_DIGITS; i++) begin
      if (b[4*i +: 4] >= 4'd5) begin
        r[4*i +: 4] = b[4*i +: 4] + 4'd3;
      end
    end
    return r;
  endfunction

endpackage

/* sv/ftdt_bcd.sv */
// ----------------------------------------------------------------------------
// Binary to BCD converter
// Serial double dabble that shifts in two bits of the integer part per cycle.
// ----------------------------------------------------------------------------
module ftdt_bcd (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic [ftdt_pkg::BIN_W-1:0]             bin_i,
  output logic                                   done_o,
  output logic [ftdt_pkg::INT_DIGITS-1:0][3:0]   digits_o
);

  logic [ftdt_pkg::BIN_W-1:0]  bin_q, bin_d;
  logic [ftdt_pkg::BCD_W-1:0]  bcd_q, bcd_d;
  logic [ftdt_pkg::BCD_W-1:0]  adj_a, adj_b, mid;
  logic [ftdt_pkg::STEP_W-1:0] cnt_q, cnt_d;
  logic                        run_q, run_d;

  always_comb begin
    adj_a = ftdt_pkg::dabble_adj(bcd_q);
    mid   = {adj_a[ftdt_pkg::BCD_W-2:0], bin_q[ftdt_pkg::BIN_W-1]};
    adj_b = ftdt_pkg::dabble_adj(mid);

    bin_d = bin_q;
    bcd_d = bcd_q;
    cnt_d = cnt_q;
    run_d = run_q;
    if (start_i) begin
      bin_d = bin_i;
      bcd_d = '0;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      bin_d = bin_q << 2;
      bcd_d = {adj_b[ftdt_pkg::BCD_W-2:0], bin_q[ftdt_pkg::BIN_W-2]};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == ftdt_pkg::STEP_W'(ftdt_pkg::DABBLE_STEPS - 1)) begin
        run_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign done_o   = !run_q;
  assign digits_o = bcd_q;

endmodule

/* sv/ftdt_frac.sv */
// ----------------------------------------------------------------------------
// Fraction digit generator
// Multiplies the 24-bit fraction by ten once per cycle and shifts the
// integer part of each product into a digit register.
// ----------------------------------------------------------------------------
module ftdt_frac #(
  parameter int unsigned FRAC_DIGITS = ftdt_pkg::FRAC_DIGITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ftdt_pkg::FRAC_W-1:0]   frac_i,
  output logic                          done_o,
  output logic [4*FRAC_DIGITS-1:0]      digits_o
);

  localparam int unsigned CntW = (FRAC_DIGITS > 1) ? $clog2(FRAC_DIGITS) : 1;

  logic [ftdt_pkg::FRAC_W-1:0] f_q, f_d;
  logic [ftdt_pkg::FRAC_W+3:0] prod;
  logic [4*FRAC_DIGITS-1:0]    dig_q, dig_d;
  logic [CntW-1:0]             cnt_q, cnt_d;
  logic                        run_q, run_d;

  always_comb begin
    // Times ten as eight times plus two times.
    prod = {1'b0, f_q, 3'b000} + {3'b000, f_q, 1'b0};

    f_d   = f_q;
    dig_d = dig_q;
    cnt_d = cnt_q;
    run_d = run_q;
    if (start_i) begin
      f_d   = frac_i;
      dig_d = '0;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      // The first digit ends up in the lowest slot after the last step.
      f_d   = prod[ftdt_pkg::FRAC_W-1:0];
      dig_d = dig_q >> 4;
      dig_d[4*FRAC_DIGITS-1 -: 4] = prod[ftdt_pkg::FRAC_W+3 -: 4];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(FRAC_DIGITS - 1)) begin
        run_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    f_q   <= f_d;
    dig_q <= dig_d;
  end

  assign done_o   = !run_q;
  assign digits_o = dig_q;

endmodule

/* sv/ftdt_emit.sv */
// ----------------------------------------------------------------------------
// Character emitter
// Copies a finished conversion and sends it one character per cycle
// while the output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module ftdt_emit #(
  parameter int unsigned FRAC_DIGITS = ftdt_pkg::FRAC_DIGITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  ftdt_pkg::ftdt_job_t                   job_i,
  input  logic [ftdt_pkg::INT_DIGITS-1:0][3:0]  int_digits_i,
  input  logic [4*FRAC_DIGITS-1:0]              frac_digits_i,
  output logic                                  ready_o,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output ftdt_pkg::ftdt_out_t                   out_data_o
);

  ftdt_pkg::ftdt_phase_e                 phase_q, phase_d;
  ftdt_pkg::ftdt_status_e                status_q;
  logic [ftdt_pkg::INT_DIGITS-1:0][3:0]  int_q;
  logic [4*FRAC_DIGITS-1:0]              frac_q;
  logic [ftdt_pkg::NDIG_W-1:0]           idx_q;
  logic [ftdt_pkg::KEPT_W-1:0]           cnt_q;
  logic                                  out_valid_q;
  ftdt_pkg::ftdt_out_t                   out_q, char_w;
  logic                                  load, emit;

  // The output register can take a new character when empty or draining.
  assign load = !out_valid_q || !out_stall_i;

  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      ftdt_pkg::PH_IDLE: begin
        if (start_i) begin
          if (job_i.fail) begin
            phase_d = ftdt_pkg::PH_FAIL;
          end else if (job_i.neg) begin
            phase_d = ftdt_pkg::PH_SIGN;
          end else begin
            phase_d = ftdt_pkg::PH_INT;
          end
        end
      end
      ftdt_pkg::PH_SIGN: if (load) phase_d = ftdt_pkg::PH_INT;
      ftdt_pkg::PH_INT: if (load && idx_q == '0) phase_d = ftdt_pkg::PH_DOT;
      ftdt_pkg::PH_DOT: if (load) phase_d = ftdt_pkg::PH_FRAC;
      ftdt_pkg::PH_FRAC: begin
        if (load && cnt_q == ftdt_pkg::KEPT_W'(1)) phase_d = ftdt_pkg::PH_TERM;
      end
      ftdt_pkg::PH_TERM: if (load) phase_d = ftdt_pkg::PH_IDLE;
      ftdt_pkg::PH_FAIL: if (load) phase_d = ftdt_pkg::PH_IDLE;
      default: phase_d = ftdt_pkg::PH_IDLE;
    endcase
  end

  always_comb begin
    char_w.char_code = ftdt_pkg::CH_NUL;
    char_w.status    = ftdt_pkg::ST_OK;
    char_w.last      = 1'b0;
    emit             = load;
    case (phase_q)
      ftdt_pkg::PH_IDLE: emit = 1'b0;
      ftdt_pkg::PH_SIGN: char_w.char_code = ftdt_pkg::CH_MINUS;
      ftdt_pkg::PH_INT:  char_w.char_code = ftdt_pkg::CH_ZERO + {4'd0, int_q[idx_q]};
      ftdt_pkg::PH_DOT:  char_w.char_code = ftdt_pkg::CH_DOT;
      ftdt_pkg::PH_FRAC: char_w.char_code = ftdt_pkg::CH_ZERO + {4'd0, frac_q[3:0]};
      ftdt_pkg::PH_TERM: char_w.last = 1'b1;
      ftdt_pkg::PH_FAIL: begin
        char_w.status = status_q;
        char_w.last   = 1'b1;
      end
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= ftdt_pkg::PH_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= char_w;
    end
    if (phase_q == ftdt_pkg::PH_IDLE && start_i) begin
      int_q    <= int_digits_i;
      frac_q   <= frac_digits_i;
      status_q <= job_i.status;
      cnt_q    <= job_i.kept;
      // With no integer digits the slot at index zero holds a zero digit.
      idx_q    <= (job_i.nd == '0) ? '0 : job_i.nd - 1'b1;
    end else if (emit && phase_q == ftdt_pkg::PH_INT) begin
      idx_q <= idx_q - 1'b1;
    end else if (emit && phase_q == ftdt_pkg::PH_FRAC) begin
      frac_q <= frac_q >> 4;
      cnt_q  <= cnt_q - 1'b1;
    end
  end

  assign ready_o     = (phase_q == ftdt_pkg::PH_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> phase_q == ftdt_pkg::PH_IDLE)
    else $error("emitter started while busy");

  a_frac_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == ftdt_pkg::PH_FRAC |-> cnt_q != '0)
    else $error("fraction phase with no digits left");

  a_fail_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != ftdt_pkg::ST_OK) |->
      (out_data_o.char_code == ftdt_pkg::CH_NUL && out_data_o.last))
    else $error("failure item is not a lone terminator");

endmodule

/* sv/float_to_decimal_text_top.sv */
// ----------------------------------------------------------------------------
// Float to decimal text converter, top level
// Turns an IEEE single precision value into ASCII decimal characters.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid_i, in_stall_o, in_data_i) takes one item: the
// float bits and the buffer capacity. An item is taken on a clock edge where
// in_valid_i is high and in_stall_o is low. The output channel (out_valid_o,
// out_stall_i, out_data_o) gives one character per item: optional '-', the
// integer digits or '0', '.', the fraction digits and a NUL with last set.
// When the value or the buffer does not fit, a single NUL item with last set
// carries the status instead.
// Sequence: a two-bit double dabble of the integer part (the fraction
// digits are made alongside, one per cycle), a wait until both converters
// are done, the room checks and the hand-off, after which the emitter
// starts and registers the first character, then one character per cycle
// while not stalled.
// The emitter keeps its own copy of the digits, so the next item is taken
// and converted while the previous text still goes out.
// Reset clears all control state; the outputs show no valid item after it.
// A stall on the output holds the output register and the emitter; a
// conversion that finishes meanwhile waits in the hand-off state.
// ----------------------------------------------------------------------------
module float_to_decimal_text_top #(
  parameter int unsigned FRAC_DIGITS = ftdt_pkg::FRAC_DIGITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ftdt_pkg::ftdt_in_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ftdt_pkg::ftdt_out_t  out_data_o
);

  ftdt_pkg::ftdt_ctrl_e state_q, state_d;

  // Capture-side decode of the incoming item.
  logic                                 accept;
  logic [7:0]                           exp_w;
  logic [7:0]                           shift_w;
  logic                                 is_zero;
  logic [ftdt_pkg::ROOM_W-1:0]          room_sat;
  logic [23:0]                          mant;
  logic [ftdt_pkg::FIX_W-1:0]           fixed;
  logic [ftdt_pkg::BIN_W-1:0]           ipart;
  logic [ftdt_pkg::FRAC_W-1:0]          fpart;
  ftdt_pkg::ftdt_status_e               pre_status;

  logic [ftdt_pkg::ROOM_W-1:0]          room_q;
  logic                                 neg_q;
  ftdt_pkg::ftdt_job_t                  job_q, job_d;
  logic                                 job_we;

  // Converter outputs.
  logic                                 bcd_start, bcd_done;
  logic                                 frac_done;
  logic [ftdt_pkg::INT_DIGITS-1:0][3:0] int_dig;
  logic [4*FRAC_DIGITS-1:0]             frac_dig;

  // Room checks.
  logic [ftdt_pkg::NDIG_W-1:0]          nd_w;
  logic [ftdt_pkg::KEPT_W-1:0]          cnt_w, kept_w;
  logic [ftdt_pkg::ROOM_W-1:0]          r1, r2, r3, r4;
  logic                                 chk_fail;

  logic                                 emit_ready, emit_start;

  assign in_stall_o = (state_q != ftdt_pkg::CT_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // Classify the value and place it into 31.24 fixed point: the mantissa
  // with 31 zeros appended is shifted right by 157 minus the exponent.
  always_comb begin
    exp_w    = in_data_i.float_bits[30:23];
    is_zero  = (in_data_i.float_bits[30:0] == 31'd0);
    room_sat = (in_data_i.capacity > ftdt_pkg::ROOM_MAX) ? ftdt_pkg::ROOM_MAX
                                                         : in_data_i.capacity;
    mant     = is_zero ? 24'd0 : {1'b1, in_data_i.float_bits[22:0]};
    shift_w  = ftdt_pkg::EXP_SHIFT_BASE - exp_w;
    fixed    = {mant, 31'd0} >> shift_w[5:0];
    ipart    = {1'b0, fixed[ftdt_pkg::FIX_W-1 -: ftdt_pkg::IPART_W]};
    fpart    = fixed[ftdt_pkg::FRAC_W-1:0];

    // Zero is checked first; it needs room for "0.0" and the terminator.
    if (is_zero) begin
      pre_status = (room_sat < ftdt_pkg::ROOM_ZERO_MIN) ? ftdt_pkg::ST_ROOM
                                                        : ftdt_pkg::ST_OK;
    end else if (exp_w >= ftdt_pkg::EXP_LARGE) begin
      pre_status = ftdt_pkg::ST_LARGE;
    end else if (exp_w < ftdt_pkg::EXP_SMALL) begin
      pre_status = ftdt_pkg::ST_SMALL;
    end else begin
      pre_status = ftdt_pkg::ST_OK;
    end
  end

  assign bcd_start = accept && (pre_status == ftdt_pkg::ST_OK);

  ftdt_bcd u_bcd (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (bcd_start),
    .bin_i    (ipart),
    .done_o   (bcd_done),
    .digits_o (int_dig)
  );

  ftdt_frac #(
    .FRAC_DIGITS (FRAC_DIGITS)
  ) u_frac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (bcd_start),
    .frac_i   (fpart),
    .done_o   (frac_done),
    .digits_o (frac_dig)
  );

  // Room accounting once all digits are known. Each step uses the room
  // left by the one before; a failure sticks even if later values wrap.
  // The sign, integer digits, point, kept fraction digits and terminator
  // each take one unit; the lone '0' before the point takes none.
  always_comb begin
    nd_w = '0;
    for (int i = 0; i < ftdt_pkg::INT_DIGITS; i++) begin
      if (int_dig[i] != 4'd0) begin
        nd_w = ftdt_pkg::NDIG_W'(i + 1);
      end
    end

    chk_fail = 1'b0;
    if (neg_q && room_q == '0) chk_fail = 1'b1;
    r1 = room_q - {{(ftdt_pkg::ROOM_W-1){1'b0}}, neg_q};
    if ({2'b00, nd_w} > r1) chk_fail = 1'b1;
    r2 = r1 - {2'b00, nd_w};
    if (r2 == '0) chk_fail = 1'b1;
    r3 = r2 - 1'b1;
    if (r3 == '0) chk_fail = 1'b1;

    // Digits produced: the lesser of the fraction width and the room left.
    cnt_w = (r3 < ftdt_pkg::ROOM_W'(FRAC_DIGITS)) ? r3[ftdt_pkg::KEPT_W-1:0]
                                                   : ftdt_pkg::KEPT_W'(FRAC_DIGITS);
    // Trailing zeros are dropped, but one fraction digit always stays.
    kept_w = ftdt_pkg::KEPT_W'(1);
    for (int j = 0; j < FRAC_DIGITS; j++) begin
      if (ftdt_pkg::KEPT_W'(j) < cnt_w && frac_dig[4*j +: 4] != 4'd0) begin
        kept_w = ftdt_pkg::KEPT_W'(j + 1);
      end
    end
    r4 = r3 - {{(ftdt_pkg::ROOM_W-ftdt_pkg::KEPT_W){1'b0}}, kept_w};
    if (r4 == '0) chk_fail = 1'b1;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ftdt_pkg::CT_IDLE: begin
        if (accept) begin
          state_d = (pre_status == ftdt_pkg::ST_OK) ? ftdt_pkg::CT_CONV
                                                    : ftdt_pkg::CT_HAND;
        end
      end
      ftdt_pkg::CT_CONV:  if (bcd_done && frac_done) state_d = ftdt_pkg::CT_CHECK;
      ftdt_pkg::CT_CHECK: state_d = ftdt_pkg::CT_HAND;
      ftdt_pkg::CT_HAND:  if (emit_ready) state_d = ftdt_pkg::CT_IDLE;
      default:            state_d = ftdt_pkg::CT_IDLE;
    endcase
  end

  // Outputs of the control sequence: the job record and the hand-off.
  always_comb begin
    job_we     = 1'b0;
    job_d      = job_q;
    emit_start = 1'b0;
    case (state_q)
      ftdt_pkg::CT_IDLE: begin
        if (accept && pre_status != ftdt_pkg::ST_OK) begin
          job_we      = 1'b1;
          job_d.fail  = 1'b1;
          job_d.status = pre_status;
          job_d.neg   = 1'b0;
          job_d.nd    = '0;
          job_d.kept  = ftdt_pkg::KEPT_W'(1);
        end
      end
      ftdt_pkg::CT_CHECK: begin
        job_we       = 1'b1;
        job_d.fail   = chk_fail;
        job_d.status = chk_fail ? ftdt_pkg::ST_ROOM : ftdt_pkg::ST_OK;
        job_d.neg    = neg_q;
        job_d.nd     = nd_w;
        job_d.kept   = kept_w;
      end
      ftdt_pkg::CT_HAND: emit_start = emit_ready;
      default: emit_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ftdt_pkg::CT_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      room_q <= room_sat;
      // Zero prints without a sign.
      neg_q  <= in_data_i.float_bits[31] && !is_zero;
    end
    if (job_we) begin
      job_q <= job_d;
    end
  end

  ftdt_emit #(
    .FRAC_DIGITS (FRAC_DIGITS)
  ) u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (emit_start),
    .job_i         (job_q),
    .int_digits_i  (int_dig),
    .frac_digits_i (frac_dig),
    .ready_o       (emit_ready),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_o    (out_data_o)
  );

  a_check_after_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ftdt_pkg::CT_CHECK |-> (bcd_done && frac_done))
    else $error("room check before digits are complete");

  a_accept_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o)
    else $error("second item taken during a conversion");

  a_fail_has_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ftdt_pkg::CT_HAND && job_q.fail) |-> job_q.status != ftdt_pkg::ST_OK)
    else $error("failed job without a failure status");

endmodule

/* bench/tb_float_to_decimal_text_top.sv */
// ----------------------------------------------------------------------------
// Float to decimal text converter testbench
// Sends single precision values with buffer capacities and checks every
// character item against a predictor that prints the value in software.
// ----------------------------------------------------------------------------
module tb_float_to_decimal_text_top;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  ftdt_pkg::ftdt_in_t  in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  ftdt_pkg::ftdt_out_t out_data_o;

  // Values waiting to be sent, and characters the converter still owes us.
  ftdt_pkg::ftdt_in_t  to_send_q[$];
  ftdt_pkg::ftdt_out_t expected_chars_q[$];
  int unsigned         mismatches = 0;

  // The sender sees at a falling edge whether its item was taken at the
  // rising edge before.
  logic in_took = 1'b0;

  // When low, neither side inserts gaps or stalls.
  bit gaps_on = 1'b1;

  float_to_decimal_text_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic void push_char(logic [7:0] ch, ftdt_pkg::ftdt_status_e st,
                                    logic last);
    ftdt_pkg::ftdt_out_t res;
    res.char_code = ch;
    res.status    = st;
    res.last      = last;
    expected_chars_q.push_back(res);
  endfunction

  // Works out the text for one value and queues one item per character.
  // A conversion that fails queues a single NUL item that carries the status.
  function automatic void predict_text(ftdt_pkg::ftdt_in_t item);
    logic [31:0] bits;
    logic [31:0] mant;
    logic [31:0] ipart;
    logic [31:0] fpart;
    logic [7:0]  text[$];
    logic [7:0]  dig[$];
    int          room;
    int          e;
    int          start;
    int          count;
    bits  = item.float_bits;
    room  = (item.capacity > ftdt_pkg::ROOM_MAX) ? 32 : int'(item.capacity);
    ipart = '0;
    fpart = '0;
    if (bits[30:0] == '0) begin
      // Zero of either sign prints without a sign and needs four places.
      if (room < 4) begin
        push_char(ftdt_pkg::CH_NUL, ftdt_pkg::ST_ROOM, 1'b1);
        return;
      end
      text.push_back(ftdt_pkg::CH_ZERO);
      text.push_back(ftdt_pkg::CH_DOT);
      text.push_back(ftdt_pkg::CH_ZERO);
    end else begin
      e    = int'(bits[30:23]) - 127;
      mant = {8'd0, 1'b1, bits[22:0]};
      if (e >= 31) begin
        push_char(ftdt_pkg::CH_NUL, ftdt_pkg::ST_LARGE, 1'b1);
        return;
      end
      if (e < -23) begin
        push_char(ftdt_pkg::CH_NUL, ftdt_pkg::ST_SMALL, 1'b1);
        return;
      end
      // Split into a 31-bit integer and a 24-bit binary fraction.
      if (e >= 23) begin
        ipart = mant << (e - 23);
      end else if (e >= 0) begin
        ipart = mant >> (23 - e);
        fpart = (mant << (e + 1)) & 32'h00FF_FFFF;
      end else begin
        fpart = mant >> (-(e + 1));
      end
      if (bits[31]) begin
        if (room <= 0) begin
          push_char(ftdt_pkg::CH_NUL, ftdt_pkg::ST_ROOM, 1'b1);
          return;
        end
        room--;
        text.push_back(ftdt_pkg::CH_MINUS);
      end
      // A lone integer zero costs no room.
      if (ipart == '0) begin
        text.push_back(ftdt_pkg::CH_ZERO);
      end else begin
        while (ipart != '0) begin
          dig.push_front(ftdt_pkg::CH_ZERO + 8'(ipart % 10));
          ipart = ipart / 10;
        end
        if (dig.size() > room) begin
          push_char(ftdt_pkg::CH_NUL, ftdt_pkg::ST_ROOM, 1'b1);
          return;
        end
        foreach (dig[i]) text.push_back(dig[i]);
        room -= dig.size();
      end
      if (room <= 0) begin
        push_char(ftdt_pkg::CH_NUL, ftdt_pkg::ST_ROOM, 1'b1);
        return;
      end
      room--;
      text.push_back(ftdt_pkg::CH_DOT);
      if (room <= 0) begin
        push_char(ftdt_pkg::CH_NUL, ftdt_pkg::ST_ROOM, 1'b1);
        return;
      end
      if (fpart == '0) begin
        room--;
        text.push_back(ftdt_pkg::CH_ZERO);
      end else begin
        // Truncated digits, as many as fit; trailing zeros give room back.
        start = text.size();
        count = (room < int'(ftdt_pkg::FRAC_DIGITS_DEF)) ? room
                                                        : int'(ftdt_pkg::FRAC_DIGITS_DEF);
        for (int i = 0; i < count; i++) begin
          fpart = fpart * 10;
          text.push_back(ftdt_pkg::CH_ZERO + 8'(fpart >> 24));
          fpart = fpart & 32'h00FF_FFFF;
        end
        while (text.size() - 1 > start && text[text.size() - 1] == ftdt_pkg::CH_ZERO) begin
          void'(text.pop_back());
        end
        room -= text.size() - start;
      end
    end
    // The terminator needs one more place.
    if (room <= 0) begin
      push_char(ftdt_pkg::CH_NUL, ftdt_pkg::ST_ROOM, 1'b1);
      return;
    end
    foreach (text[i]) push_char(text[i], ftdt_pkg::ST_OK, 1'b0);
    push_char(ftdt_pkg::CH_NUL, ftdt_pkg::ST_OK, 1'b1);
  endfunction

  // Sender: a new item or a gap is chosen only once the current item has
  // been taken, so a stalled item stays on the bus unchanged.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_took)) begin
      if (to_send_q.size() != 0 && !(gaps_on && $urandom_range(0, 99) < 35)) begin
        in_valid_i <= 1'b1;
        in_data_i  <= to_send_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver stalls at random on every falling edge.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_stall_i <= gaps_on && ($urandom_range(0, 99) < 35);
    end
  end

  // At each rising edge, a taken input item is predicted and a taken output
  // item is compared with the oldest character still owed.
  always @(posedge clk_i) begin
    ftdt_pkg::ftdt_out_t want;
    in_took <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      predict_text(in_data_i);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_chars_q.size() == 0) begin
        $display("%0t: unexpected item char_code %h status %0d last %b", $time,
                 out_data_o.char_code, out_data_o.status, out_data_o.last);
        mismatches++;
      end else begin
        want = expected_chars_q.pop_front();
        if (out_data_o.char_code !== want.char_code) begin
          $display("%0t: char_code expected %h actual %h", $time,
                   want.char_code, out_data_o.char_code);
          mismatches++;
        end
        if (out_data_o.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   want.status, out_data_o.status);
          mismatches++;
        end
        if (out_data_o.last !== want.last) begin
          $display("%0t: last expected %b actual %b", $time,
                   want.last, out_data_o.last);
          mismatches++;
        end
      end
    end
  end

  task automatic queue_item(logic [31:0] bits, logic [5:0] cap);
    ftdt_pkg::ftdt_in_t item;
    item.float_bits = bits;
    item.capacity   = cap;
    to_send_q.push_back(item);
  endtask

  // Random values: mostly exponents that convert, some near the range limits,
  // some zeros and some raw bit patterns. Capacities lean toward sizes that
  // fit, with a share that runs out of room or saturates.
  task automatic queue_random(int n);
    ftdt_pkg::ftdt_in_t item;
    int unsigned        sel;
    for (int i = 0; i < n; i++) begin
      sel             = $urandom_range(0, 99);
      item.float_bits = $urandom;
      if (sel < 65) begin
        item.float_bits[30:23] = 8'($urandom_range(104, 157));
      end else if (sel < 78) begin
        item.float_bits[30:23] = 8'($urandom_range(98, 163));
      end else if (sel < 84) begin
        item.float_bits[30:0] = '0;
      end
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        item.capacity = 6'($urandom_range(8, 32));
      end else if (sel < 90) begin
        item.capacity = 6'($urandom_range(0, 7));
      end else begin
        item.capacity = 6'($urandom_range(33, 63));
      end
      to_send_q.push_back(item);
    end
  endtask

  // Waits until every queued item is taken and every
  // character owed has come out.
  task automatic drain_all();
    while (to_send_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_chars_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Zeros of both signs, with just enough room and too little.
    queue_item(32'h0000_0000, 6'd4);
    queue_item(32'h8000_0000, 6'd4);
    queue_item(32'h0000_0000, 6'd3);
    queue_item(32'h8000_0000, 6'd0);
    // Capacity above 32 acts as 32; simple signed values.
    queue_item(32'h3F80_0000, 6'd63);
    queue_item(32'hBFC0_0000, 6'd32);
    // Largest exponent that still converts, of both signs.
    queue_item(32'h4EFF_FFFF, 6'd32);
    queue_item(32'hCEFF_FFFF, 6'd32);
    // Too large: exponent 31, infinity and a negative NaN.
    queue_item(32'h4F00_0000, 6'd32);
    queue_item(32'h7F80_0000, 6'd32);
    queue_item(32'hFFC0_0001, 6'd32);
    // Too small just below the limit, smallest that converts, a subnormal.
    queue_item(32'h33FF_FFFF, 6'd32);
    queue_item(32'h3400_0000, 6'd32);
    queue_item(32'h8000_0001, 6'd32);
    // Fraction digits cut by the room left, and a trimmed fraction.
    queue_item(32'h3DCC_CCCD, 6'd3);
    queue_item(32'h3DCC_CCCD, 6'd6);
    // No room for the sign, for the integer digits, for the point.
    queue_item(32'hBF80_0000, 6'd0);
    queue_item(32'h4640_E400, 6'd4);
    queue_item(32'h4640_E400, 6'd5);
    // No room for the lone fraction zero; a half with little room.
    queue_item(32'h3F80_0000, 6'd2);
    queue_item(32'h3F00_0000, 6'd4);
    // Around the point where the fraction part disappears.
    queue_item(32'h4B00_0000, 6'd32);
    queue_item(32'h4AFF_FFFF, 6'd12);
    queue_item(32'h3FFF_FFFF, 6'd9);
    // A fraction that uses all seven digits.
    queue_item(32'h3EAA_AAAB, 6'd32);
    drain_all();

    queue_random(45);
    drain_all();

    // A stretch where both sides run flat out.
    gaps_on = 1'b0;
    queue_random(40);
    drain_all();
    gaps_on = 1'b1;

    queue_random(50);
    drain_all();

    // Let any stray items show up before the verdict.
    repeat (60) @(posedge clk_i);
    if (mismatches == 0 && expected_chars_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

/* sim.f */
sv/ftdt_pkg.sv
sv/ftdt_bcd.sv
sv/ftdt_frac.sv
sv/ftdt_emit.sv
sv/float_to_decimal_text_top.sv
bench/tb_float_to_decimal_text_top.sv
